@@ rtl/core/dsew_pkg.sv @@
// ----------------------------------------------------------------------------
// dsew_pkg
// Shared types and constants of the delayed sound event wheel.
// ----------------------------------------------------------------------------
package dsew_pkg;

  localparam int SLOTS            = 64;
  localparam int ENTRIES_PER_SLOT = 16;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int FILL_W  = $clog2(ENTRIES_PER_SLOT + 1);
  localparam int DEPTH   = SLOTS * ENTRIES_PER_SLOT;
  localparam int ADDR_W  = $clog2(DEPTH);

  // raw delay = delay + 1 + jitter, at most 63 + 1 + 15
  localparam int RAW_W   = 7;
  localparam int CMP_W   = ((RAW_W > SLOT_W) ? RAW_W : SLOT_W) + 1;

  localparam int JIT_W        = 4;
  localparam logic [JIT_W-1:0] JITTER_RESET = 4'd8;

  localparam int CFG_AW  = 3;
  localparam logic [CFG_AW-3:0] REG_JITTER_MAX = '0;

  localparam logic FUNC_REGISTER = 1'b0;
  localparam logic FUNC_TICK     = 1'b1;

  typedef struct packed {
    logic               func;
    logic [9:0]         sound_id;
    logic [9:0]         volume;
    logic signed [15:0] pan;
    logic [15:0]        freq_rate;
    logic [5:0]         delay;
    logic               loop;
    logic [11:0]        actor_id;
  } in_t;

  typedef struct packed {
    logic [9:0]         out_sound_id;
    logic [9:0]         out_volume;
    logic signed [15:0] out_pan;
    logic [15:0]        out_freq_rate;
    logic               out_loop;
    logic [11:0]        out_actor_id;
    logic               last;
  } out_t;

  // one stored request
  typedef struct packed {
    logic [11:0]        actor_id;
    logic               loop;
    logic [9:0]         volume;
    logic [9:0]         sound_id;
    logic [15:0]        freq_rate;
    logic signed [15:0] pan;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic accept_reg;
    logic accept_tick;
    logic reg_wr;
    logic tk_fill;
    logic tk_rd;
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic rd_last;
  } stat_t;

endpackage

@@ rtl/core/dsew_ram.sv @@
// ----------------------------------------------------------------------------
// dsew_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dsew_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/dsew_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsew_ctrl
// Sequencer: request insert and tick drain.
// ----------------------------------------------------------------------------
module dsew_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           func,
  input  dsew_pkg::stat_t stat,
  output dsew_pkg::cmd_t  cmd,
  output logic           busy
);

  typedef enum logic [2:0] {
    IDLE,
    REG_WR,
    TK_FILL,
    TK_RD,
    TK_TAIL
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   accept;

  assign accept = start && (state_r == IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      IDLE: begin
        if (accept) begin
          if (func == dsew_pkg::FUNC_TICK) begin
            cmd.accept_tick = 1'b1;
            state_nxt       = TK_FILL;
          end else begin
            cmd.accept_reg = 1'b1;
            state_nxt      = REG_WR;
          end
        end
      end
      REG_WR: begin
        cmd.reg_wr = 1'b1;
        state_nxt  = IDLE;
      end
      TK_FILL: begin
        cmd.tk_fill = 1'b1;
        state_nxt   = stat.fill_zero ? IDLE : TK_RD;
      end
      TK_RD: begin
        cmd.tk_rd = 1'b1;
        if (stat.rd_last) begin
          state_nxt = TK_TAIL;
        end
      end
      TK_TAIL: begin
        state_nxt = IDLE;
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  assign busy_nxt = (state_nxt != IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

@@ rtl/core/dsew_datapath.sv @@
// ----------------------------------------------------------------------------
// dsew_datapath
// Slot arithmetic, fill tracking, entry store and result registers.
// ----------------------------------------------------------------------------
module dsew_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dsew_pkg::in_t                 in_data,
  input  logic [dsew_pkg::JIT_W-1:0]    jitter_max,
  input  dsew_pkg::cmd_t                cmd,
  output dsew_pkg::stat_t               stat,
  output logic                          out_valid,
  output dsew_pkg::out_t                out_data
);

  localparam int SW = dsew_pkg::SLOT_W;
  localparam int FW = dsew_pkg::FILL_W;
  localparam int AW = dsew_pkg::ADDR_W;

  logic [SW-1:0]               wheel_r, wheel_nxt, wheel_inc;
  logic [SW-1:0]               tgt_r, tgt_nxt, tgt_calc;
  logic [dsew_pkg::JIT_W-1:0]  jit_r, jit_nxt;
  logic [dsew_pkg::SLOTS-1:0]  valid_r, valid_nxt;
  logic [FW-1:0]               cnt_r, cnt_nxt, k_r, k_nxt;
  logic                        pend_r, pend_nxt, last_r, last_nxt;
  dsew_pkg::entry_t            item_r, item_nxt, ent_rd;

  logic [dsew_pkg::RAW_W-1:0]  raw;
  logic [SW-1:0]               dly;
  logic [SW:0]                 pos_sum;
  logic [SW-1:0]               fill_raddr;
  logic [FW-1:0]               fill_rdata, fill_reg_n, fill_tk_n;
  logic                        room;
  logic                        accept;
  logic [AW-1:0]               ent_waddr, ent_raddr;
  logic [dsew_pkg::ENTRY_W-1:0] ent_rdata;

  assign accept = cmd.accept_reg || cmd.accept_tick;

  // target slot: wheel + min(delay + 1 + jitter, SLOTS-1), modulo SLOTS
  always_comb begin
    raw = dsew_pkg::RAW_W'(in_data.delay) + dsew_pkg::RAW_W'(1)
        + dsew_pkg::RAW_W'(jit_r);
    if (dsew_pkg::CMP_W'(raw) > dsew_pkg::CMP_W'(dsew_pkg::SLOTS - 1)) begin
      dly = SW'(dsew_pkg::SLOTS - 1);
    end else begin
      dly = SW'(raw);
    end
    pos_sum = {1'b0, wheel_r} + {1'b0, dly};
    if (pos_sum >= (SW + 1)'(dsew_pkg::SLOTS)) begin
      pos_sum = pos_sum - (SW + 1)'(dsew_pkg::SLOTS);
    end
    tgt_calc = pos_sum[SW-1:0];
  end

  assign wheel_inc  = (wheel_r == SW'(dsew_pkg::SLOTS - 1)) ? '0 : wheel_r + SW'(1);
  assign fill_raddr = (in_data.func == dsew_pkg::FUNC_TICK) ? wheel_inc : tgt_calc;

  // an unmarked slot holds nothing, whatever the RAM says
  assign fill_reg_n = valid_r[tgt_r]   ? fill_rdata : '0;
  assign fill_tk_n  = valid_r[wheel_r] ? fill_rdata : '0;
  assign room       = (fill_reg_n < FW'(dsew_pkg::ENTRIES_PER_SLOT));

  assign ent_waddr = AW'(tgt_r) * AW'(dsew_pkg::ENTRIES_PER_SLOT) + AW'(fill_reg_n);
  assign ent_raddr = AW'(wheel_r) * AW'(dsew_pkg::ENTRIES_PER_SLOT) + AW'(k_r);

  assign stat.fill_zero = (fill_tk_n == '0);
  assign stat.rd_last   = ((k_r + FW'(1)) == cnt_r);

  always_comb begin
    wheel_nxt = wheel_r;
    tgt_nxt   = tgt_r;
    jit_nxt   = jit_r;
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    item_nxt  = item_r;
    pend_nxt  = cmd.tk_rd;
    last_nxt  = cmd.tk_rd && stat.rd_last;
    if (cmd.accept_reg) begin
      tgt_nxt            = tgt_calc;
      jit_nxt            = (jit_r >= jitter_max) ? '0 : jit_r + dsew_pkg::JIT_W'(1);
      item_nxt.actor_id  = in_data.actor_id;
      item_nxt.loop      = in_data.loop;
      item_nxt.volume    = in_data.volume;
      item_nxt.sound_id  = in_data.sound_id;
      item_nxt.freq_rate = in_data.freq_rate;
      item_nxt.pan       = in_data.pan;
    end
    if (cmd.accept_tick) begin
      wheel_nxt = wheel_inc;
      jit_nxt   = '0;
    end
    if (cmd.reg_wr && room) begin
      valid_nxt[tgt_r] = 1'b1;
    end
    if (cmd.tk_fill) begin
      valid_nxt[wheel_r] = 1'b0;
      cnt_nxt            = fill_tk_n;
      k_nxt              = '0;
    end
    if (cmd.tk_rd) begin
      k_nxt = k_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_r <= '0;
      jit_r   <= '0;
      valid_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      wheel_r <= wheel_nxt;
      jit_r   <= jit_nxt;
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r  <= tgt_nxt;
    cnt_r  <= cnt_nxt;
    k_r    <= k_nxt;
    item_r <= item_nxt;
    last_r <= last_nxt;
  end

  dsew_ram #(
    .WIDTH (FW),
    .DEPTH (dsew_pkg::SLOTS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (cmd.reg_wr && room),
    .waddr (tgt_r),
    .wdata (fill_reg_n + FW'(1)),
    .re    (accept),
    .raddr (fill_raddr),
    .rdata (fill_rdata)
  );

  dsew_ram #(
    .WIDTH (dsew_pkg::ENTRY_W),
    .DEPTH (dsew_pkg::DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.reg_wr && room),
    .waddr (ent_waddr),
    .wdata (item_r),
    .re    (cmd.tk_rd),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign ent_rd = ent_rdata;

  assign out_valid              = pend_r;
  assign out_data.out_sound_id  = ent_rd.sound_id;
  assign out_data.out_volume    = ent_rd.volume;
  assign out_data.out_pan       = ent_rd.pan;
  assign out_data.out_freq_rate = ent_rd.freq_rate;
  assign out_data.out_loop      = ent_rd.loop;
  assign out_data.out_actor_id  = ent_rd.actor_id;
  assign out_data.last          = last_r;

endmodule

@@ rtl/core/delayed_sound_event_wheel_core.sv @@
// ----------------------------------------------------------------------------
// delayed_sound_event_wheel_core
// Timing wheel that holds sound-play requests until their frame tick.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: a request (in_data) is taken at a clock edge with start high
//    and busy low. func selects insert (register a sound) or frame tick.
//  - Insert: lands in the slot delay+1+jitter ahead of the wheel, capped at
//    SLOTS-1 ahead; dropped when that slot already holds ENTRIES_PER_SLOT
//    entries. The slot fill-count RAM is read, then written; busy stays high
//    through the write, so the next insert waits until this one is through.
//  - Tick: advances the wheel and drains the new slot, one entry per cycle
//    from the entry RAM read port, in insertion order. A tick reads the
//    slot fill count (TK_FILL) and ends there on an empty slot; else it reads
//    the entries (TK_RD) and passes a tail state (TK_TAIL) before idle.
//  - Results: out_valid marks each result for exactly one cycle;
//    out_data.last flags the final entry of a tick. The receiver has no
//    back-pressure and must take every strobe.
//  - Config: APB-style port, jitter_max at byte address 0 (4 bits, reset 8).
//    Write only while busy is low.
//  - Reset: synchronous, active low. Clears wheel position, jitter counter
//    and per-slot valid bits (no RAM clearing pass is needed); jitter_max
//    returns to 8. The block accepts requests as soon as reset is released.
// ----------------------------------------------------------------------------
module delayed_sound_event_wheel_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        start,
  output logic                        busy,
  input  dsew_pkg::in_t               in_data,
  // result channel
  output logic                        out_valid,
  output dsew_pkg::out_t              out_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsew_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  dsew_pkg::cmd_t              cmd;
  dsew_pkg::stat_t             stat;
  logic [dsew_pkg::JIT_W-1:0]  jitter_max_r, jitter_max_nxt;
  logic                        cfg_wr;
  logic                        cfg_hit;

  // ---- configuration register --------------------------------------------
  // word index sits above the byte offset
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[dsew_pkg::CFG_AW-1:2] == dsew_pkg::REG_JITTER_MAX);
  assign cfg_wr  = psel && penable && pwrite && pready;

  assign jitter_max_nxt = (cfg_wr && cfg_hit) ? pwdata[dsew_pkg::JIT_W-1:0]
                                              : jitter_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jitter_max_r <= dsew_pkg::JITTER_RESET;
    end else begin
      jitter_max_r <= jitter_max_nxt;
    end
  end

  assign prdata = cfg_hit ? {{(32 - dsew_pkg::JIT_W){1'b0}}, jitter_max_r} : '0;

  // ---- sequencer ----------------------------------------------------------
  dsew_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_data.func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // ---- datapath: slot math, fill counts, entry store ----------------------
  dsew_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .jitter_max (jitter_max_r),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  // ---- assertions ---------------------------------------------------------
  // results only come out of a tick in progress
  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // an accepted request holds the block for at least the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted request did not hold busy");

  // nothing follows the last entry of a tick directly
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |=> !out_valid)
    else $error("result strobe after last entry");

endmodule

@@ tb/sound_wheel_checker.sv @@
// ----------------------------------------------------------------------------
// sound_wheel_checker
// Watches the request, result and configuration channels of the sound event
// wheel. It keeps its own copy of the wheel and predicts every emitted entry,
// then compares each strobed result field by field with the oldest one due.
// ----------------------------------------------------------------------------
module sound_wheel_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  dsew_pkg::in_t               in_data,
  input  logic                        out_valid,
  input  dsew_pkg::out_t              out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsew_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  output logic [31:0]                 n_pending,
  output logic [31:0]                 n_failed,
  output logic [31:0]                 n_checked,
  output logic [31:0]                 n_dropped
);

  import dsew_pkg::*;

  logic [JIT_W-1:0] jit_limit;
  logic [JIT_W-1:0] jit_cnt;
  int unsigned      wheel_pos;
  int unsigned      fill [SLOTS];
  entry_t           held [SLOTS][ENTRIES_PER_SLOT];
  out_t             due_sounds [$];

  initial begin
    n_pending = '0;
    n_failed  = '0;
    n_checked = '0;
    n_dropped = '0;
  end

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      n_failed = n_failed + 1;
    end
  endtask

  // insert: jitter taken before the counter steps, distance capped one short
  // of a full turn
  task automatic schedule_request(input in_t req);
    int unsigned jit;
    int unsigned ahead;
    int unsigned slot;
    entry_t      e;
    jit = int'(jit_cnt);
    if (jit_cnt >= jit_limit) jit_cnt = '0;
    else jit_cnt = jit_cnt + 1'b1;
    ahead = int'(req.delay) + 1 + jit;
    if (ahead > SLOTS - 1) ahead = SLOTS - 1;
    slot = (wheel_pos + ahead) % SLOTS;
    if (fill[slot] >= ENTRIES_PER_SLOT) begin
      n_dropped = n_dropped + 1;
    end else begin
      e.actor_id  = req.actor_id;
      e.loop      = req.loop;
      e.volume    = req.volume;
      e.sound_id  = req.sound_id;
      e.freq_rate = req.freq_rate;
      e.pan       = req.pan;
      held[slot][fill[slot]] = e;
      fill[slot] = fill[slot] + 1;
    end
  endtask

  // tick: step the wheel, queue the new slot's entries in insertion order
  task automatic advance_frame();
    out_t        r;
    entry_t      e;
    int unsigned n;
    wheel_pos = (wheel_pos + 1) % SLOTS;
    n = fill[wheel_pos];
    for (int unsigned k = 0; k < n; k++) begin
      e = held[wheel_pos][k];
      r.out_sound_id  = e.sound_id;
      r.out_volume    = e.volume;
      r.out_pan       = e.pan;
      r.out_freq_rate = e.freq_rate;
      r.out_loop      = e.loop;
      r.out_actor_id  = e.actor_id;
      r.last          = (k + 1 == n);
      due_sounds.push_back(r);
    end
    fill[wheel_pos] = 0;
    jit_cnt = '0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      jit_limit = JITTER_RESET;
      jit_cnt   = '0;
      wheel_pos = 0;
      foreach (fill[i]) fill[i] = 0;
      due_sounds.delete();
    end else begin
      // results first: one strobed now can never come from a request taken
      // at this same edge
      if (out_valid) begin
        if (due_sounds.size() == 0) begin
          $error("result strobed with none due: %p", out_data);
          n_failed = n_failed + 1;
        end else begin
          out_t want;
          want = due_sounds.pop_front();
          compare_field("out_sound_id", 32'(want.out_sound_id), 32'(out_data.out_sound_id));
          compare_field("out_volume", 32'(want.out_volume), 32'(out_data.out_volume));
          compare_field("out_pan", 32'(want.out_pan), 32'(out_data.out_pan));
          compare_field("out_freq_rate", 32'(want.out_freq_rate),
                        32'(out_data.out_freq_rate));
          compare_field("out_loop", 32'(want.out_loop), 32'(out_data.out_loop));
          compare_field("out_actor_id", 32'(want.out_actor_id), 32'(out_data.out_actor_id));
          compare_field("last", 32'(want.last), 32'(out_data.last));
          n_checked = n_checked + 1;
        end
      end
      if (psel && penable && pready && (paddr[CFG_AW-1:2] == REG_JITTER_MAX)) begin
        if (pwrite) jit_limit = pwdata[JIT_W-1:0];
        else compare_field("prdata", 32'(jit_limit), 32'(prdata[JIT_W-1:0]));
      end
      if (start && !busy) begin
        if (in_data.func == FUNC_TICK) advance_frame();
        else schedule_request(in_data);
      end
    end
    n_pending = 32'(due_sounds.size());
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the delayed sound event wheel core. A directed
// opening covers field extremes, full slots, capped delays, empty ticks and
// a jitter counter left above a lowered limit; bursts of random requests and
// ticks follow under several jitter limits, and a full turn of ticks drains
// the wheel. All checking lives in the checker instance.
// ----------------------------------------------------------------------------
module testbench;

  import dsew_pkg::*;

  // cycles a request may still be in flight after the last result is out
  localparam int SETTLE_CYCLES = 8;
  // least number of random requests per jitter setting
  localparam int PHASE_ITEMS   = 20;
  localparam int PHASES        = 5;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  in_t               in_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;

  wire               busy;
  wire               out_valid;
  out_t              out_data;
  wire  [31:0]       prdata;
  wire               pready;

  wire  [31:0]       n_pending;
  wire  [31:0]       n_failed;
  wire  [31:0]       n_checked;
  wire  [31:0]       n_dropped;

  int unsigned       n_sent;
  int unsigned       burst_left;

  always #4 clk = ~clk;

  delayed_sound_event_wheel_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  sound_wheel_checker wheel_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .n_pending (n_pending),
    .n_failed  (n_failed),
    .n_checked (n_checked),
    .n_dropped (n_dropped)
  );

  // Request content. All fields but func and delay are random over their full
  // width; pan covers all 16 bits, not only the Q1.14 range: it passes through.
  function automatic in_t make_request(input logic func, input int unsigned dly);
    in_t r;
    r.func      = func;
    r.sound_id  = 10'($urandom_range(0, 1023));
    r.volume    = 10'($urandom_range(0, 1023));
    r.pan       = 16'($urandom());
    r.freq_rate = 16'($urandom());
    r.delay     = 6'(dly);
    r.loop      = 1'($urandom_range(0, 1));
    r.actor_id  = 12'($urandom_range(0, 4095));
    return r;
  endfunction

  // Mostly short delays so slots come due within a few ticks; some spread
  // over the whole wheel and some hit the cap.
  function automatic int unsigned pick_delay();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, 5);
    if (sel < 9) return $urandom_range(0, 63);
    return 63;
  endfunction

  // Idle the request channel; start drops at the first falling edge, so
  // it is never lowered and raised in one step.
  task automatic hold_off(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Present one request and wait for the edge that takes it (start high,
  // busy low). The sender runs in bursts: when a burst is used up a random
  // gap follows, now and then a long one.
  task automatic issue(input in_t item);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    n_sent = n_sent + 1;
    if (burst_left > 0) burst_left = burst_left - 1;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) hold_off($urandom_range(15, 30));
      else hold_off($urandom_range(1, 5));
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Drop start and wait until no result is due, then let an insert or an
  // empty tick still in flight finish. Sampled at falling edges, where the
  // checker's counters are stable.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic cfg_access(input logic wr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_JITTER_MAX, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // New jitter limit, read back at once; only ever called from idle.
  task automatic set_jitter(input int unsigned value);
    cfg_access(1'b1, 32'(value));
    cfg_access(1'b0, '0);
  endtask

  initial begin
    in_t         req;
    int unsigned phase_items;
    int unsigned k;
    int unsigned fixed_delay;
    bit          crowded;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    n_sent     = 0;
    burst_left = $urandom_range(1, 12);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed: reset limit of 8, counter at 0, wheel at 0 ----
    // All-ones request but for pan 0x4000, delay 0: lands one slot ahead.
    req           = make_request(FUNC_REGISTER, 0);
    req.sound_id  = '1;
    req.volume    = '1;
    req.pan       = 16'sh4000;
    req.freq_rate = '1;
    req.loop      = 1'b1;
    req.actor_id  = '1;
    issue(req);
    // All-zero request but for pan -16384, with the longest delay: capped one
    // short of a turn, it comes back only in the final drain.
    req           = '0;
    req.func      = FUNC_REGISTER;
    req.pan       = -16'sd16384;
    req.delay     = 6'd63;
    issue(req);
    // First tick emits the all-ones entry, the second finds an empty slot.
    issue(make_request(FUNC_TICK, 0));
    issue(make_request(FUNC_TICK, $urandom_range(0, 63)));
    settle();

    // ---- directed: limit 0, so no jitter; 17 requests aim at one slot ----
    // The last one finds the slot full and is dropped.
    set_jitter(0);
    repeat (ENTRIES_PER_SLOT + 1) issue(make_request(FUNC_REGISTER, 0));
    issue(make_request(FUNC_TICK, 0));
    settle();

    // ---- directed: counter left above a lowered limit ----
    // Three requests under limit 15 leave the counter at 3; with the limit
    // cut to 1 it is used once more and then wraps.
    set_jitter(15);
    repeat (3) issue(make_request(FUNC_REGISTER, $urandom_range(0, 5)));
    settle();
    set_jitter(1);
    repeat (2) issue(make_request(FUNC_REGISTER, $urandom_range(0, 5)));
    settle();

    // ---- random phases, each under its own jitter limit ----
    // Most sequences are a run of inserts followed by a few ticks; a crowded
    // run reuses one delay to overfill slots. The rest is noise with random
    // functions. Each phase starts from idle, so the sender also waits here
    // until every due result is out.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0) set_jitter(0);
      else if (p == 1) set_jitter(15);
      else set_jitter($urandom_range(0, 15));
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          k           = $urandom_range(1, 18);
          crowded     = ($urandom_range(0, 3) == 0);
          fixed_delay = pick_delay();
          repeat (k) begin
            issue(make_request(FUNC_REGISTER, crowded ? fixed_delay : pick_delay()));
          end
          phase_items = phase_items + k;
          k = $urandom_range(1, 3);
          repeat (k) issue(make_request(FUNC_TICK, $urandom_range(0, 63)));
          phase_items = phase_items + k;
        end else begin
          k = $urandom_range(1, 6);
          repeat (k) begin
            issue(make_request(1'($urandom_range(0, 1)), $urandom_range(0, 63)));
          end
          phase_items = phase_items + k;
        end
      end
    end

    // ---- drain: a full turn of ticks brings every held entry out ----
    repeat (SLOTS) issue(make_request(FUNC_TICK, $urandom_range(0, 63)));
    settle();
    repeat (4 * SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d requests over %0d jitter settings plus a full drain turn;",
             n_sent, PHASES + 4);
    $display("%0d results compared, %0d requests dropped on full slots.",
             n_checked, n_dropped);
    if (n_failed == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/dsew_pkg.sv
rtl/core/dsew_ram.sv
rtl/core/dsew_ctrl.sv
rtl/core/dsew_datapath.sv
rtl/core/delayed_sound_event_wheel_core.sv
tb/sound_wheel_checker.sv
tb/testbench.sv
